@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros shared by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, masked while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every rising clock edge, masked while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ sv/nwtl_pkg.sv @@
// ---------------------------------------------------------------------------
// nwtl_pkg
// types and constants of the night window trust latch
// ---------------------------------------------------------------------------
package nwtl_pkg;

   localparam int unsigned MINUTE_W  = 11;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 8;

   // register reset values
   localparam logic [MINUTE_W-1:0] WINDOW_START_RST = 11'd1320;
   localparam logic [MINUTE_W-1:0] WINDOW_END_RST   = 11'd420;
   localparam logic [TIME_W-1:0]   TRUST_AGE_RST    = 32'd3600000;
   localparam logic [TIME_W-1:0]   RESYNC_IVL_RST   = 32'd300000;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NIGHT_ENABLED  = 3'd0,
      CSR_WINDOW_START   = 3'd1,
      CSR_WINDOW_END     = 3'd2,
      CSR_TRUST_AGE      = 3'd3,
      CSR_RESYNC_IVL     = 3'd4
   } csr_index_type;

   // request kinds carried in tuser
   typedef enum logic {
      ACTION_TICK = 1'b0,
      ACTION_SYNC = 1'b1
   } action_type;

   // request payload, highest field first
   typedef struct packed {
      action_type          action;
      logic [MINUTE_W-1:0] minute_of_day;
      logic                time_valid;
      logic [TIME_W-1:0]   now_ms;
   } req_payload_type;

   // result payload
   typedef struct packed {
      logic resync_request;
      logic night_held;
      logic night_active;
   } rsp_payload_type;

endpackage

@@ sv/night_window_trust_latch_core.sv @@
// ---------------------------------------------------------------------------
// night_window_trust_latch_core
// night-mode gate that latches only on trusted time and rate-limits resyncs
// ---------------------------------------------------------------------------
// Usage: requests arrive on req_* with the kind in req_tuser (0 service tick,
// 1 sync completed) and now_ms, time_valid, minute_of_day in req_tdata. Each
// request gives exactly one result on rsp_* carrying night_active, night_held
// and resync_request.
// Pipeline: an accepted request is held in the request register, which feeds
// the result register through combinational logic. Throughput is one request
// per cycle while results are taken; the window test and the two 32-bit age
// compares sit in the logic between the two registers.
// Stall: while a result waits and rsp_tready is low the result register holds and the request
// register still takes one more request; then req_tready drops.
// Reset (synchronous): both stages empty, registers back to their defaults
// (disabled, window 22:00 to 07:00, trust 3600000 ms, resync 300000 ms),
// night flags clear, never synced.
// Registers are written through csr_*, by the user only while no request is in
// flight (unenforced); a write takes effect for the next request processed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module night_window_trust_latch_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // now_ms [31:0], time_valid [32], minute_of_day [43:33], zero [47:44]
   input  logic [nwtl_pkg::REQ_DATA_W-1:0]       req_tdata,
   // action [0]
   input  logic                                  req_tuser,
   // result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // night_active [0], night_held [1], resync_request [2], zero [7:3]
   output logic [nwtl_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // configuration write port
   input  logic                                  csr_we,
   input  logic [nwtl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [nwtl_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // configuration registers
   logic                                night_enabled_ff;
   logic [nwtl_pkg::MINUTE_W-1:0]       window_start_ff;
   logic [nwtl_pkg::MINUTE_W-1:0]       window_end_ff;
   logic [nwtl_pkg::TIME_W-1:0]         trust_age_ff;
   logic [nwtl_pkg::TIME_W-1:0]         resync_ivl_ff;

   // block state
   logic                                latched_ff,     latched_in;
   logic                                active_ff,      active_in;
   logic                                held_ff,        held_in;
   logic [nwtl_pkg::TIME_W-1:0]         last_resync_ff, last_resync_in;
   logic                                ever_synced_ff, ever_synced_in;
   logic [nwtl_pkg::TIME_W-1:0]         last_sync_ff,   last_sync_in;

   // pipeline
   logic                                in_valid_ff;
   nwtl_pkg::req_payload_type           in_data_ff;
   logic                                out_valid_ff;
   nwtl_pkg::rsp_payload_type           out_data_ff,    out_data_in;

   logic                                advance;
   logic                                in_window;
   logic [nwtl_pkg::TIME_W-1:0]         sync_age;
   logic [nwtl_pkg::TIME_W-1:0]         resync_age;
   logic                                pulse;
   nwtl_pkg::req_payload_type           req_payload;

   // unpack request
   assign req_payload.action        = nwtl_pkg::action_type'(req_tuser);
   assign req_payload.minute_of_day = req_tdata[43:33];
   assign req_payload.time_valid    = req_tdata[32];
   assign req_payload.now_ms        = req_tdata[31:0];

   // handshake
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(nwtl_pkg::RSP_DATA_W - 3){1'b0}}, out_data_ff};

   // window test, wrapping past midnight, empty window never matches
   always_comb begin
      if (window_start_ff == window_end_ff) begin
         in_window = 1'b0;
      end else if (window_start_ff < window_end_ff) begin
         in_window = (in_data_ff.minute_of_day >= window_start_ff) &&
                     (in_data_ff.minute_of_day < window_end_ff);
      end else begin
         in_window = (in_data_ff.minute_of_day >= window_start_ff) ||
                     (in_data_ff.minute_of_day < window_end_ff);
      end
   end

   // wrapping ages
   assign sync_age   = in_data_ff.now_ms - last_sync_ff;
   assign resync_age = in_data_ff.now_ms - last_resync_ff;

   // state update for the request in the input register
   always_comb begin
      latched_in     = latched_ff;
      active_in      = active_ff;
      held_in        = held_ff;
      last_resync_in = last_resync_ff;
      ever_synced_in = ever_synced_ff;
      last_sync_in   = last_sync_ff;
      pulse          = 1'b0;
      if (in_data_ff.action == nwtl_pkg::ACTION_SYNC) begin
         last_sync_in   = in_data_ff.now_ms;
         ever_synced_in = 1'b1;
      end else if (!night_enabled_ff || !(in_data_ff.time_valid && in_window)) begin
         latched_in     = 1'b0;
         active_in      = 1'b0;
         held_in        = 1'b0;
         last_resync_in = '0;
      end else if (latched_ff) begin
         active_in = 1'b1;
         held_in   = 1'b0;
      end else if (ever_synced_ff && (sync_age <= trust_age_ff)) begin
         latched_in = 1'b1;
         active_in  = 1'b1;
         held_in    = 1'b0;
      end else begin
         active_in = 1'b0;
         held_in   = 1'b1;
         if ((last_resync_ff == '0) || (resync_age >= resync_ivl_ff)) begin
            last_resync_in = {in_data_ff.now_ms[nwtl_pkg::TIME_W-1:1], 1'b1};
            pulse          = 1'b1;
         end
      end
      out_data_in.night_active   = active_in;
      out_data_in.night_held     = held_in;
      out_data_in.resync_request = pulse;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         night_enabled_ff <= 1'b0;
         window_start_ff  <= nwtl_pkg::WINDOW_START_RST;
         window_end_ff    <= nwtl_pkg::WINDOW_END_RST;
         trust_age_ff     <= nwtl_pkg::TRUST_AGE_RST;
         resync_ivl_ff    <= nwtl_pkg::RESYNC_IVL_RST;
      end else if (csr_we) begin
         unique case (nwtl_pkg::csr_index_type'(csr_index))
            nwtl_pkg::CSR_NIGHT_ENABLED: night_enabled_ff <= csr_wdata[0];
            nwtl_pkg::CSR_WINDOW_START:  window_start_ff  <= csr_wdata[nwtl_pkg::MINUTE_W-1:0];
            nwtl_pkg::CSR_WINDOW_END:    window_end_ff    <= csr_wdata[nwtl_pkg::MINUTE_W-1:0];
            nwtl_pkg::CSR_TRUST_AGE:     trust_age_ff     <= csr_wdata;
            nwtl_pkg::CSR_RESYNC_IVL:    resync_ivl_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // block state, committed as each request moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff     <= 1'b0;
         active_ff      <= 1'b0;
         held_ff        <= 1'b0;
         last_resync_ff <= '0;
         ever_synced_ff <= 1'b0;
         last_sync_ff   <= '0;
      end else if (advance) begin
         latched_ff     <= latched_in;
         active_ff      <= active_in;
         held_ff        <= held_in;
         last_resync_ff <= last_resync_in;
         ever_synced_ff <= ever_synced_in;
         last_sync_ff   <= last_sync_in;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_payload;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // checks
   `ASSERT_IMPLY(a_latch_means_active, clock, reset, latched_ff,
                 active_ff && !held_ff, "latched without active")
   `ASSERT_CLK(a_active_held_excl, clock, reset, !(active_ff && held_ff),
               "active and held together")
   `ASSERT_IMPLY(a_resync_stamp_odd, clock, reset, last_resync_ff != '0,
                 last_resync_ff[0], "resync stamp bit 0 clear")
   `ASSERT_IMPLY(a_pulse_only_held, clock, reset,
                 out_valid_ff && out_data_ff.resync_request,
                 out_data_ff.night_held && !out_data_ff.night_active,
                 "resync pulse outside hold")

endmodule
